[sv/aoqr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aoqr_pkg
// Shared constants and types for the AND/OR query rank accumulator.
// ---------------------------------------------------------------------------
package aoqr_pkg;

	localparam int DOCS      = 128;
	localparam int MAX_TERMS = 63;

	localparam int ADDR_W  = $clog2(DOCS);
	localparam int MATCH_W = $clog2(MAX_TERMS + 1);
	localparam int CNT_W   = 16;
	localparam int RANK_W  = 24;
	localparam int CMD_W   = 3;
	localparam int DOC_W   = 7;

	localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_TERM  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POST  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_GEND  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0]   min_count;
		logic [MATCH_W-1:0] hits;
	} grp_word_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		grp_word_t         word;
	} grp_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [RANK_W-1:0] rank;
	} mst_wr_t;

endpackage

[sv/aoqr_grp_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aoqr_grp_table
// Group table: min count and match count per document in a synchronous
// memory, with per-entry valid flops that clear together at group end.
// ---------------------------------------------------------------------------
module aoqr_grp_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [aoqr_pkg::ADDR_W-1:0] rd_addr,
	output aoqr_pkg::grp_word_t        rd_word,
	input  logic [aoqr_pkg::ADDR_W-1:0] vld_addr,
	output logic                       vld,
	input  aoqr_pkg::grp_wr_t          wr,
	input  logic                       clr_all
);

	aoqr_pkg::grp_word_t mem [aoqr_pkg::DOCS];
	logic [aoqr_pkg::DOCS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.word;
		end
		if (rd_en) begin
			rd_word <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_all) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	assign vld = valid_q[vld_addr];

endmodule

[sv/aoqr_mst_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aoqr_mst_table
// Master table: accumulated rank per document in a synchronous memory,
// with per-entry valid flops that a clear command drops at once.
// ---------------------------------------------------------------------------
module aoqr_mst_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [aoqr_pkg::ADDR_W-1:0] rd_addr,
	output logic [aoqr_pkg::RANK_W-1:0] rd_rank,
	input  logic [aoqr_pkg::ADDR_W-1:0] vld_addr,
	output logic                        vld,
	input  aoqr_pkg::mst_wr_t           wr,
	input  logic                        clr_all
);

	logic [aoqr_pkg::RANK_W-1:0] mem [aoqr_pkg::DOCS];
	logic [aoqr_pkg::DOCS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.rank;
		end
		if (rd_en) begin
			rd_rank <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_all) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	assign vld = valid_q[vld_addr];

endmodule

[sv/and_or_query_rank_accumulator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// and_or_query_rank_accumulator
// Command-driven document score accumulator for AND/OR boolean queries.
// ---------------------------------------------------------------------------
// Postings stream one per cycle while the input is not stalled, through a
// read-modify-write of the group memory, with the last write forwarded to a
// posting of the same document right behind it. A read goes through the
// master memory read and then lands in the output register, and it holds
// off the input until that register is free. Group end sweeps both memories
// one document per cycle and stalls input through its sweep and drain
// states, as each memory has a single read port.
// Reset needs no clearing pass: valid flops mark live entries.
// ---------------------------------------------------------------------------
module and_or_query_rank_accumulator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [aoqr_pkg::CMD_W-1:0]   command,
	input  logic [aoqr_pkg::DOC_W-1:0]   doc_id,
	input  logic [aoqr_pkg::CNT_W-1:0]   term_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [aoqr_pkg::RANK_W-1:0]  rank
);

	localparam int AW = aoqr_pkg::ADDR_W;
	localparam int MW = aoqr_pkg::MATCH_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam logic [AW-1:0] LAST_DOC  = AW'(aoqr_pkg::DOCS - 1);
	localparam logic [MW-1:0] MAX_MATCH = MW'(aoqr_pkg::MAX_TERMS);

	logic [1:0]    state_q;
	logic [AW-1:0] sweep_cnt_q;
	logic [MW-1:0] group_terms_q;

	logic                       post_s1, rd_s1, sweep_s1;
	logic [AW-1:0]              addr_s1;
	logic [aoqr_pkg::CNT_W-1:0] cnt_s1;
	logic                       rng_s1;

	logic                fwd_s2;
	logic [AW-1:0]       fwd_addr_s2;
	aoqr_pkg::grp_word_t fwd_word_s2;

	logic                found_q;
	logic [aoqr_pkg::RANK_W-1:0] rank_q;
	logic                out_valid_q;

	logic in_fire, in_range;
	logic [AW-1:0] doc_addr;

	logic                grp_rd_en, mst_rd_en, grp_clr, mst_clr;
	logic [AW-1:0]       grp_rd_addr, mst_rd_addr;
	aoqr_pkg::grp_word_t grp_rd_word, grp_old;
	logic                grp_vld, mst_vld;
	logic [aoqr_pkg::RANK_W-1:0] mst_rd_rank;
	aoqr_pkg::grp_wr_t   grp_wr;
	aoqr_pkg::mst_wr_t   mst_wr;
	logic [aoqr_pkg::RANK_W:0] rank_sum;
	logic                out_load, sweep_last;

	assign in_stall = (state_q != ST_IDLE) || rd_s1 || (out_valid_q && out_stall);
	assign in_fire  = in_valid && !in_stall;
	assign doc_addr = doc_id[AW-1:0];
	assign in_range = 32'(doc_id) < aoqr_pkg::DOCS;

	// memory read port control
	always_comb begin
		grp_rd_en   = 1'b0;
		grp_rd_addr = doc_addr;
		mst_rd_en   = 1'b0;
		mst_rd_addr = doc_addr;
		mst_clr     = 1'b0;
		if (state_q == ST_SWEEP) begin
			grp_rd_en   = 1'b1;
			grp_rd_addr = sweep_cnt_q;
			mst_rd_en   = 1'b1;
			mst_rd_addr = sweep_cnt_q;
		end else if (in_fire) begin
			grp_rd_en = (command == aoqr_pkg::CMD_POST) && in_range;
			mst_rd_en = (command == aoqr_pkg::CMD_READ) && in_range;
			mst_clr   = (command == aoqr_pkg::CMD_CLEAR);
		end
	end

	// posting update and merge, both in stage 1
	always_comb begin
		grp_old = (fwd_s2 && fwd_addr_s2 == addr_s1) ? fwd_word_s2 : grp_rd_word;
		grp_wr  = '0;
		grp_wr.addr = addr_s1;
		if (post_s1) begin
			grp_wr.en = 1'b1;
			if (!grp_vld) begin
				grp_wr.word.min_count = cnt_s1;
				grp_wr.word.hits      = MW'(1);
			end else begin
				grp_wr.word.hits = (grp_old.hits < MAX_MATCH) ?
					grp_old.hits + MW'(1) : grp_old.hits;
				grp_wr.word.min_count = (cnt_s1 < grp_old.min_count) ?
					cnt_s1 : grp_old.min_count;
			end
		end

		rank_sum = {1'b0, mst_rd_rank} + (aoqr_pkg::RANK_W + 1)'(grp_rd_word.min_count);
		mst_wr      = '0;
		mst_wr.addr = addr_s1;
		mst_wr.en   = sweep_s1 && grp_vld && (grp_rd_word.hits >= group_terms_q);
		if (!mst_vld) begin
			mst_wr.rank = aoqr_pkg::RANK_W'(grp_rd_word.min_count);
		end else if (rank_sum[aoqr_pkg::RANK_W]) begin
			mst_wr.rank = aoqr_pkg::RANK_MAX;
		end else begin
			mst_wr.rank = rank_sum[aoqr_pkg::RANK_W-1:0];
		end
	end

	assign sweep_last = (state_q == ST_DRAIN) && sweep_s1;
	assign grp_clr    = sweep_last;
	assign out_load   = rd_s1;

	aoqr_grp_table u_grp (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (grp_rd_en),
		.rd_addr  (grp_rd_addr),
		.rd_word  (grp_rd_word),
		.vld_addr (addr_s1),
		.vld      (grp_vld),
		.wr       (grp_wr),
		.clr_all  (grp_clr)
	);

	aoqr_mst_table u_mst (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (mst_rd_en),
		.rd_addr  (mst_rd_addr),
		.rd_rank  (mst_rd_rank),
		.vld_addr (addr_s1),
		.vld      (mst_vld),
		.wr       (mst_wr),
		.clr_all  (mst_clr)
	);

	// sequencer and term counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sweep_cnt_q   <= '0;
			group_terms_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && command == aoqr_pkg::CMD_TERM &&
					    group_terms_q < MAX_MATCH) begin
						group_terms_q <= group_terms_q + MW'(1);
					end
					if (in_fire && command == aoqr_pkg::CMD_GEND) begin
						state_q     <= ST_SWEEP;
						sweep_cnt_q <= '0;
					end
				end
				ST_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + AW'(1);
					if (sweep_cnt_q == LAST_DOC) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last merge commits this cycle
					state_q       <= ST_IDLE;
					group_terms_q <= '0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// stage 1 and forward stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_s1  <= 1'b0;
			rd_s1    <= 1'b0;
			sweep_s1 <= 1'b0;
			fwd_s2   <= 1'b0;
		end else begin
			post_s1  <= in_fire && command == aoqr_pkg::CMD_POST && in_range;
			rd_s1    <= in_fire && command == aoqr_pkg::CMD_READ;
			sweep_s1 <= (state_q == ST_SWEEP);
			fwd_s2   <= post_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= (state_q == ST_SWEEP) ? sweep_cnt_q : doc_addr;
		cnt_s1      <= term_count;
		rng_s1      <= in_range;
		fwd_addr_s2 <= addr_s1;
		fwd_word_s2 <= grp_wr.word;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q <= rng_s1 && mst_vld;
			rank_q  <= (rng_s1 && mst_vld) ? mst_rd_rank : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign rank      = rank_q;

`ifndef SYNTH
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input taken during group sweep");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep_s1 && (post_s1 || rd_s1)))
		else $error("sweep overlaps a posting or read in stage 1");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |=> out_valid_q)
		else $error("read result not loaded into output register");

	a_terms_cap: assert property (@(posedge clk) disable iff (!arst_n)
		group_terms_q <= MAX_MATCH)
		else $error("term counter above cap");
`endif

endmodule
